@@ rtl/lssc_pkg.sv @@
package lssc_pkg;

  // Configuration register width and its value after reset.
  localparam int unsigned CFG_W = 16;
  localparam logic [CFG_W-1:0] SETTLE_RESET = 16'd200;

  // Position field: signed Q.8, saturated to the field range.
  localparam int unsigned POS_W = 11;
  localparam logic signed [POS_W-1:0] POS_MAX = 11'sd1023;
  localparam logic signed [POS_W-1:0] POS_MIN = -11'sd1024;

  // Widths of the fixed output fields.
  localparam int unsigned SEL_W  = 3;
  localparam int unsigned BITS_W = 8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic tick;      // accept one input beat
    logic load_pos;  // take the divider result as the new position
  } lssc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_div;  // the beat on offer completes a scan with lit sensors
    logic div_done;  // divider result is ready
  } lssc_sts_t;

endpackage

@@ rtl/lssc_div.sv @@
module lssc_div import lssc_pkg::*; #(
  parameter int unsigned NUM_W = 16,
  parameter int unsigned DEN_W = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic             run_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // One restoring step: bring down the next numerator bit and try the subtract.
  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  // Control of the iteration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CNT_W'(NUM_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and quotient, one bit per cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (run_r) begin
      quo_r <= {quo_r[NUM_W-2:0], ge};
      rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

@@ rtl/lssc_dp.sv @@
module lssc_dp import lssc_pkg::*; #(
  parameter int unsigned SENSOR_COUNT = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [CFG_W-1:0]        cfg_wr_data,
  input  logic                    in_sense_level,
  input  lssc_cmd_t               cmd,
  output lssc_sts_t               sts,
  output logic [SEL_W-1:0]        out_mux_select,
  output logic                    out_scan_done,
  output logic [BITS_W-1:0]       out_line_bits,
  output logic signed [POS_W-1:0] out_position_q8,
  output logic                    out_line_lost
);

  localparam int unsigned CH_W  = $clog2(SENSOR_COUNT);
  localparam int unsigned SUM_W = $clog2(SENSOR_COUNT * SENSOR_COUNT) + 1;
  localparam int unsigned CNT_W = $clog2(SENSOR_COUNT + 1);
  localparam int unsigned NUM_W = SUM_W + 9;
  localparam int unsigned DEN_W = CNT_W + 1;
  localparam int unsigned WOFF  = SENSOR_COUNT - 1;

  // Scan state.
  logic [CFG_W-1:0]        settle_ticks_r;
  logic [CFG_W-1:0]        settle_cnt_r;
  logic [CH_W-1:0]         ch_r;
  logic [SENSOR_COUNT-1:0] scan_bits_r;
  logic [SENSOR_COUNT-1:0] done_bits_r;
  logic signed [POS_W-1:0] held_pos_r;
  logic                    lost_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [CNT_W-1:0]        cnt_r;
  logic                    neg_r;

  // Output payload registers.
  logic [SEL_W-1:0]        out_sel_r;
  logic                    out_done_r;
  logic [BITS_W-1:0]       out_bits_r;
  logic signed [POS_W-1:0] out_pos_r;
  logic                    out_lost_r;

  logic                    sample;
  logic                    last;
  logic                    lit;
  logic signed [SUM_W-1:0] wt;
  logic [SENSOR_COUNT-1:0] bits_all;
  logic signed [SUM_W-1:0] sum_all;
  logic [CNT_W-1:0]        cnt_all;
  logic [SUM_W-1:0]        mag;
  logic [NUM_W-1:0]        num;
  logic [DEN_W-1:0]        den;
  logic                    div_done;
  logic [NUM_W-1:0]        quot;
  logic                    q_over_neg;
  logic                    q_over_pos;
  logic signed [POS_W-1:0] pos_res;

  // Settle timing and the sample decision for this beat.
  assign sample = !(settle_cnt_r < settle_ticks_r);
  assign last   = ch_r == CH_W'(SENSOR_COUNT - 1);
  assign lit    = sample && in_sense_level;

  // Weight of the current channel, doubled: 2*ch - (count - 1).
  assign wt = $signed(SUM_W'({ch_r, 1'b0})) - $signed(SUM_W'(WOFF));

  // Scan bits, weight sum and lit count including this beat's sample.
  assign bits_all = scan_bits_r | (lit ? (SENSOR_COUNT'(1) << ch_r) : '0);
  assign sum_all  = sum_r + (lit ? wt : '0);
  assign cnt_all  = cnt_r + CNT_W'(lit);

  assign sts.need_div = sample && last && (cnt_all != '0);
  assign sts.div_done = div_done;

  // Rounded mean: (2*|s|*128 + n) / (2*n), sign applied afterwards.
  assign mag = sum_all[SUM_W-1] ? SUM_W'(-sum_all) : SUM_W'(sum_all);
  assign num = {1'b0, mag, 8'd0} + NUM_W'(cnt_all);
  assign den = {cnt_all, 1'b0};

  lssc_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.tick && sts.need_div),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .quot  (quot)
  );

  // Apply the sign and saturate to the field range.
  assign q_over_neg = quot > NUM_W'(1024);
  assign q_over_pos = quot > NUM_W'(1023);

  always_comb begin
    if (neg_r) begin
      pos_res = q_over_neg ? POS_MIN : $signed(POS_W'(11'd0 - quot[POS_W-1:0]));
    end else begin
      pos_res = q_over_pos ? POS_MAX : $signed(quot[POS_W-1:0]);
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_ticks_r <= SETTLE_RESET;
    end else if (cfg_wr_en) begin
      settle_ticks_r <= cfg_wr_data;
    end
  end

  // Scan sequencing, accumulation and held results.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_cnt_r <= '0;
      ch_r         <= '0;
      scan_bits_r  <= '0;
      done_bits_r  <= '0;
      held_pos_r   <= '0;
      lost_r       <= 1'b0;
      sum_r        <= '0;
      cnt_r        <= '0;
      neg_r        <= 1'b0;
    end else begin
      if (cmd.tick) begin
        if (!sample) begin
          settle_cnt_r <= settle_cnt_r + 1'b1;
        end else begin
          settle_cnt_r <= '0;
          if (last) begin
            done_bits_r <= bits_all;
            lost_r      <= cnt_all == '0;
            neg_r       <= sum_all[SUM_W-1];
            scan_bits_r <= '0;
            sum_r       <= '0;
            cnt_r       <= '0;
            ch_r        <= '0;
          end else begin
            scan_bits_r <= bits_all;
            sum_r       <= sum_all;
            cnt_r       <= cnt_all;
            ch_r        <= ch_r + 1'b1;
          end
        end
      end
      if (cmd.load_pos) begin
        held_pos_r <= pos_res;
      end
    end
  end

  // Result payload for the beat just taken.
  always_ff @(posedge clk) begin
    if (cmd.tick) begin
      out_sel_r  <= SEL_W'(ch_r);
      out_done_r <= sample && last;
      out_pos_r  <= held_pos_r;
      if (sample && last) begin
        out_bits_r <= BITS_W'(bits_all);
        out_lost_r <= cnt_all == '0;
      end else begin
        out_bits_r <= BITS_W'(done_bits_r);
        out_lost_r <= lost_r;
      end
    end
    if (cmd.load_pos) begin
      out_pos_r <= pos_res;
    end
  end

  assign out_mux_select  = out_sel_r;
  assign out_scan_done   = out_done_r;
  assign out_line_bits   = out_bits_r;
  assign out_position_q8 = out_pos_r;
  assign out_line_lost   = out_lost_r;

endmodule

@@ rtl/lssc_ctrl.sv @@
module lssc_ctrl import lssc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  lssc_sts_t sts,
  output lssc_cmd_t cmd
);

  localparam logic ST_RUN = 1'b0;
  localparam logic ST_DIV = 1'b1;

  logic state_r;
  logic state_nxt;
  logic out_valid_r;
  logic out_valid_nxt;
  logic out_free;
  logic accept;

  // The output register can take a beat when empty or draining this cycle.
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == ST_RUN) && out_free);
  assign accept   = (state_r == ST_RUN) && in_valid && out_free;

  assign cmd.tick     = accept;
  assign cmd.load_pos = (state_r == ST_DIV) && sts.div_done;

  // Wait in the divide state while the position of a finished scan is worked out.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_RUN: begin
        if (accept && sts.need_div) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          state_nxt = ST_RUN;
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  // Output valid: set on a finished result, cleared when the receiver takes it.
  always_comb begin
    if ((accept && !sts.need_div) || cmd.load_pos) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ rtl/line_sensor_scan_centroid_core.sv @@
// Line sensor scanner with weighted centroid.
// Input channel: one beat per tick carries in_sense_level, the level of the
// multiplexer output pin. Each beat gives exactly one result beat on the
// output channel with the channel select driven during that tick, a scan-done
// flag, the bits of the last full scan, the line position in signed Q.8 and
// the line-lost flag. Write cfg_wr_en/cfg_wr_data only while the block is idle.
// An ordinary tick's result is registered and shown in the cycle after the
// tick is taken, so one beat per cycle is sustained while no divide runs and
// out_stall is low. A tick that finishes a scan with at least one lit sensor
// starts the bit-serial divider for the mean; the input is stalled until its
// result is loaded. A scan with no sensor lit skips the divider and its
// result is registered like an ordinary tick.
// Reset clears the scan, the position and the flags and loads settle_ticks
// with 200. When out_stall holds a result, in_stall rises and no further
// tick is taken until the result has been accepted.
module line_sensor_scan_centroid_core import lssc_pkg::*; #(
  parameter int unsigned SENSOR_COUNT = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [CFG_W-1:0]        cfg_wr_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_sense_level,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [SEL_W-1:0]        out_mux_select,
  output logic                    out_scan_done,
  output logic [BITS_W-1:0]       out_line_bits,
  output logic signed [POS_W-1:0] out_position_q8,
  output logic                    out_line_lost
);

  lssc_cmd_t cmd;
  lssc_sts_t sts;

  // Handshake and sequencing.
  lssc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Scan registers, centroid arithmetic and result payload.
  lssc_dp #(
    .SENSOR_COUNT (SENSOR_COUNT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_sense_level  (in_sense_level),
    .cmd             (cmd),
    .sts             (sts),
    .out_mux_select  (out_mux_select),
    .out_scan_done   (out_scan_done),
    .out_line_bits   (out_line_bits),
    .out_position_q8 (out_position_q8),
    .out_line_lost   (out_line_lost)
  );

endmodule
